FILE: rtl/name_binding_table_macros.svh
// Assertion macros for the name binding table.
// Used by the top level after its package import; depends on clk and arst_n in scope.
`ifndef NAME_BINDING_TABLE_MACROS_SVH
`define NAME_BINDING_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// A clocked implication that is checked outside reset.
`define NBT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define NBT_ASSERT_ALWAYS(label, expr, msg) \
	`NBT_ASSERT(label, 1'b1 |-> (expr), msg)

`else

`define NBT_ASSERT(label, prop, msg)
`define NBT_ASSERT_ALWAYS(label, expr, msg)

`endif

`endif

FILE: rtl/nbt_pkg.sv
// Shared types and constants for the name binding table.
// No dependencies; imported by the top level.
package nbt_pkg;

	// Default number of bindings the table holds.
	localparam int TABLE_DEPTH = 32;

	// Field widths.
	localparam int KEY_W = 64;
	localparam int ID_W  = 16;

	// Request opcodes.
	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_LOOKUP   = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// One request beat.
	typedef struct packed {
		logic             opcode;
		logic [KEY_W-1:0] name_key;
		logic [ID_W-1:0]  task_id;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] result_task_id;
	} rsp_t;

endpackage

FILE: rtl/nbt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the key and task id of each binding.
module nbt_ram #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
	input  logic [Width-1:0]                         wr_data,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
	output logic [Width-1:0]                         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/name_binding_table.sv
// Top level of the name binding table: request/response handshakes, scan sequencer.
// Depends on nbt_pkg, nbt_ram and name_binding_table_macros.svh.
//
// Usage:
// A request beat (opcode, name_key, task_id) is taken on req when req_valid is high
// and req_stall is low. req_stall is high while a request is being worked on, so one
// request is handled at a time. Each request gives exactly one response beat on rsp
// (status, result_task_id), held until rsp_valid is high and rsp_stall is low.
// The sequencer walks the filled entries from index 0 upward, one RAM read per cycle,
// comparing each stored key against the request key in one shared 64-bit comparator;
// the first match ends the walk. The sequencer returns to idle as the response beat is
// loaded, so the next request can be taken while that beat is presented. The registered
// read port of the table RAM puts the compare of each key in the cycle after its address
// is issued. A register request that hits or finds room writes the RAM in the cycle the
// response is loaded. If the previous response is still stalled, the finished request
// waits in place until the response register frees up. Reset clears the entry count and
// all control state; the RAM contents are not cleared and no clearing pass is needed,
// since only entries below the count are ever compared.
`include "name_binding_table_macros.svh"

module name_binding_table #(
	parameter int TableDepth = nbt_pkg::TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  nbt_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output nbt_pkg::rsp_t rsp
);

	import nbt_pkg::*;

	localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CW = $clog2(TableDepth + 1);
	localparam int EW = KEY_W + ID_W;
	localparam logic [CW-1:0] DepthC = CW'(TableDepth);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  tid_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [AW-1:0]    cmp_q;
	logic             pend_q;
	logic             hit_q;
	logic [AW-1:0]    slot_q;
	logic [ID_W-1:0]  hit_id_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic [AW-1:0]    rd_addr;
	logic [EW-1:0]    rd_data;
	logic [KEY_W-1:0] rd_key;
	logic [ID_W-1:0]  rd_id;
	logic             key_match;
	logic             issue;
	logic             out_free;
	logic             finish;
	logic             full;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [EW-1:0]    wr_data;
	rsp_t             rsp_next;

	// Handshake decode.
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == S_DONE) && out_free;

	// Scan datapath: one read per cycle, one key compare per cycle.
	assign rd_addr   = idx_q[AW-1:0];
	assign rd_key    = rd_data[EW-1:ID_W];
	assign rd_id     = rd_data[ID_W-1:0];
	assign key_match = pend_q && (rd_key == key_q);
	assign issue     = (state_q == S_SCAN) && !key_match && (idx_q < count_q);

	// Table update for a register request: overwrite on a hit, append otherwise if there is room.
	assign full    = (count_q == DepthC);
	assign wr_en   = finish && (op_q == OP_REGISTER) && (hit_q || !full);
	assign wr_addr = hit_q ? slot_q : count_q[AW-1:0];
	assign wr_data = {key_q, tid_q};

	nbt_ram #(
		.Width(EW),
		.Depth(TableDepth)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Response built from the outcome of the scan.
	always_comb begin
		if (op_q == OP_REGISTER) begin
			rsp_next.status         = (hit_q || !full) ? ST_OK : ST_FULL;
			rsp_next.result_task_id = tid_q;
		end else if (hit_q) begin
			rsp_next.status         = ST_OK;
			rsp_next.result_task_id = hit_id_q;
		end else begin
			rsp_next.status         = ST_MISSING;
			rsp_next.result_task_id = '0;
		end
	end

	// Sequencer state and registered control outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !finish) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (key_match) begin
						hit_q   <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_DONE;
					end else if (issue) begin
						pend_q <= 1'b1;
						idx_q  <= idx_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (wr_en && !hit_q) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, scan tags and the response beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.name_key;
			tid_q <= req.task_id;
		end
		if (issue) begin
			cmp_q <= idx_q[AW-1:0];
		end
		if (key_match) begin
			slot_q   <= cmp_q;
			hit_id_q <= rd_id;
		end
		if (finish) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The entry count never passes the table depth.
	`NBT_ASSERT_ALWAYS(a_count_bound, count_q <= DepthC, "entry count exceeds table depth")

	// The entry count only ever grows by one binding at a time.
	`NBT_ASSERT(a_count_step, $changed(count_q) |-> count_q == $past(count_q) + CW'(1), "count jump")

	// A new response beat appears only when a finished request is loaded.
	`NBT_ASSERT(a_rsp_source, $rose(rsp_valid_q) |-> $past(state_q == S_DONE), "response raised outside the done state")

endmodule
